// ===== src/rrl_pkg.sv =====
// shared types and codes for the round-robin ready list
package rrl_pkg;

  // request kinds as carried on in_req_type
  typedef enum logic [1:0] {
    REQ_PUSH   = 2'd0,
    REQ_TAKE   = 2'd1,
    REQ_REMOVE = 2'd2,
    REQ_NONE   = 2'd3
  } rrl_req_t;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MATCH,
    ST_UPDATE,
    ST_OUT
  } rrl_state_t;

  // per-cell control from the sequencer
  typedef struct packed {
    logic load;    // write the request id into this cell
    logic shift;   // take the neighbour's entry (close a gap)
    logic cmp_en;  // capture the key compare
  } rrl_cell_ctl_t;

endpackage

// ===== src/rrl_cell.sv =====
// one list cell: holds an entry, compares it to the key, shifts down from its neighbour
module rrl_cell #(
  parameter int ID_WIDTH = 16
) (
  input  logic                  clk,
  input  rrl_pkg::rrl_cell_ctl_t ctl,
  input  logic [ID_WIDTH-1:0]   wr_id,
  input  logic [ID_WIDTH-1:0]   nbr_id,
  input  logic [ID_WIDTH-1:0]   key,
  output logic [ID_WIDTH-1:0]   entry_o,
  output logic                  match_o
);

  logic [ID_WIDTH-1:0] entry_r;
  logic                match_r;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      entry_r <= wr_id;
    end else if (ctl.shift) begin
      entry_r <= nbr_id;
    end
    if (ctl.cmp_en) begin
      match_r <= (entry_r == key);
    end
  end

  assign entry_o = entry_r;
  assign match_o = match_r;

endmodule

// ===== src/round_robin_ready_list.sv =====
// round-robin ready list top level: request sequencer over a row of list cells
// an accepted request passes the match and update states before out_valid rises in the output state
// a new request is taken only after the previous one has gone through the match/update/output sequence
// in_stall stays high from acceptance until the result has been taken
// reset (rst_n low, synchronous) empties the list and sets the position to 0
// cell contents are not cleared; only entries below the count are ever read
module round_robin_ready_list #(
  parameter int MAX_ENTRIES = 16,
  parameter int ID_WIDTH    = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [1:0]                         in_req_type,
  input  logic [ID_WIDTH-1:0]                in_item_id,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               out_ok,
  output logic [ID_WIDTH-1:0]                out_current_id,
  output logic [$clog2(MAX_ENTRIES+1)-1:0]   out_entry_count
);

  localparam int IDX_W = $clog2(MAX_ENTRIES);
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

  // sequencer state
  rrl_pkg::rrl_state_t state_r, state_nxt;

  // request held for the whole operation
  rrl_pkg::rrl_req_t   req_r;
  logic [ID_WIDTH-1:0] id_r;

  // list bookkeeping
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [IDX_W-1:0] pos_r, pos_nxt;

  // result register
  logic                ok_r, ok_nxt;
  logic [ID_WIDTH-1:0] cur_r, cur_nxt;

  // cell row
  rrl_pkg::rrl_cell_ctl_t cell_ctl [MAX_ENTRIES];
  logic [ID_WIDTH-1:0]    cell_id  [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0] cell_match;

  // remove search results
  logic             found;
  logic [IDX_W-1:0] hit_idx;
  logic [IDX_W-1:0] pos_eff;
  logic [IDX_W-1:0] pos_tmp;
  logic             full;
  logic             upd;

  assign upd  = (state_r == rrl_pkg::ST_UPDATE);
  assign full = (cnt_r >= CNT_W'(MAX_ENTRIES));

  // a chain of identical cells; each shifts down from its upper neighbour, the top one from itself
  for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
    logic [ID_WIDTH-1:0] nbr;
    if (g == MAX_ENTRIES - 1) begin : g_top
      assign nbr = cell_id[g];
    end else begin : g_mid
      assign nbr = cell_id[g+1];
    end

    always_comb begin
      cell_ctl[g].cmp_en = (state_r == rrl_pkg::ST_MATCH);
      cell_ctl[g].load   = upd && (req_r == rrl_pkg::REQ_PUSH) && !full &&
                           (cnt_r[IDX_W-1:0] == IDX_W'(g));
      cell_ctl[g].shift  = upd && (req_r == rrl_pkg::REQ_REMOVE) && found &&
                           (IDX_W'(g) >= hit_idx);
    end

    rrl_cell #(
      .ID_WIDTH (ID_WIDTH)
    ) u_cell (
      .clk     (clk),
      .ctl     (cell_ctl[g]),
      .wr_id   (id_r),
      .nbr_id  (nbr),
      .key     (id_r),
      .entry_o (cell_id[g]),
      .match_o (cell_match[g])
    );
  end

  // last matching cell inside the live part of the list
  always_comb begin
    found   = 1'b0;
    hit_idx = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      if (cell_match[i] && (CNT_W'(i) < cnt_r)) begin
        found   = 1'b1;
        hit_idx = IDX_W'(i);
      end
    end
  end

  // operation outcome, applied in the update cycle
  always_comb begin
    cnt_nxt = cnt_r;
    pos_nxt = pos_r;
    ok_nxt  = 1'b0;
    cur_nxt = '0;
    pos_eff = (CNT_W'(pos_r) >= cnt_r) ? '0 : pos_r;
    pos_tmp = pos_r;
    case (req_r)
      rrl_pkg::REQ_PUSH: begin
        if (!full) begin
          ok_nxt  = 1'b1;
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      rrl_pkg::REQ_TAKE: begin
        if (cnt_r != '0) begin
          ok_nxt  = 1'b1;
          cur_nxt = cell_id[pos_eff];
          // wrap after the last entry
          if (CNT_W'(pos_eff) >= cnt_r - CNT_W'(1)) begin
            pos_nxt = '0;
          end else begin
            pos_nxt = pos_eff + IDX_W'(1);
          end
        end
      end
      rrl_pkg::REQ_REMOVE: begin
        if (found) begin
          ok_nxt  = 1'b1;
          cnt_nxt = cnt_r - CNT_W'(1);
          // keep the position on the same logical entry
          if (hit_idx < pos_r) begin
            pos_tmp = pos_r - IDX_W'(1);
          end
          if (CNT_W'(pos_tmp) >= cnt_r - CNT_W'(1)) begin
            pos_nxt = '0;
          end else begin
            pos_nxt = pos_tmp;
          end
        end
      end
      default: begin
        ok_nxt = 1'b0;
      end
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rrl_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = rrl_pkg::ST_MATCH;
        end
      end
      rrl_pkg::ST_MATCH: begin
        state_nxt = rrl_pkg::ST_UPDATE;
      end
      rrl_pkg::ST_UPDATE: begin
        state_nxt = rrl_pkg::ST_OUT;
      end
      rrl_pkg::ST_OUT: begin
        if (!out_stall) begin
          state_nxt = rrl_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = rrl_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rrl_pkg::ST_IDLE;
      cnt_r   <= '0;
      pos_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (upd) begin
        cnt_r <= cnt_nxt;
        pos_r <= pos_nxt;
      end
    end
  end

  // request capture and result register
  always_ff @(posedge clk) begin
    if (state_r == rrl_pkg::ST_IDLE && in_valid) begin
      req_r <= rrl_pkg::rrl_req_t'(in_req_type);
      id_r  <= in_item_id;
    end
    if (upd) begin
      ok_r  <= ok_nxt;
      cur_r <= cur_nxt;
    end
  end

  assign in_stall        = (state_r != rrl_pkg::ST_IDLE);
  assign out_valid       = (state_r == rrl_pkg::ST_OUT);
  assign out_ok          = ok_r;
  assign out_current_id  = cur_r;
  assign out_entry_count = cnt_r;

  // count never exceeds the cell row
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_ENTRIES))
    else $error("entry count beyond capacity");

  // position stays inside the live list, or at 0 when empty
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    (CNT_W'(pos_r) < cnt_r) || (pos_r == '0))
    else $error("round-robin position outside the list");

  // an accepted request gives its result after passing the match and update states
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |-> ##3 out_valid)
    else $error("result not presented on time");

  // no new request taken while a result waits
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("request accepted while a result is pending");

endmodule

// ===== verif/round_robin_ready_list_test.sv =====
// self-checking testbench for the round-robin ready list: directed table, random traffic, predictor
module round_robin_ready_list_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_ENTRIES     = 16;
  localparam int ID_W            = 16;
  localparam int CNT_W           = $clog2(MAX_ENTRIES + 1);
  localparam int RANDOM_REQUESTS = 1700;

  // one response as the block reports it
  typedef struct packed {
    logic             ok;
    logic [ID_W-1:0]  current_id;
    logic [CNT_W-1:0] entry_count;
  } list_response_t;

  // one row of the directed table; typed rows carry their own answer
  typedef struct packed {
    rrl_pkg::rrl_req_t kind;
    logic [ID_W-1:0]   id;
    logic              typed;
    list_response_t    answer;
  } directed_row_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [1:0]           in_req_type = rrl_pkg::REQ_PUSH;
  logic [ID_W-1:0]      in_item_id = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 out_ok;
  logic [ID_W-1:0]      out_current_id;
  logic [CNT_W-1:0]     out_entry_count;

  // predictor's own copy of the list
  logic [ID_W-1:0] list_ids [MAX_ENTRIES];
  int              list_len = 0;
  int              rr_pos = 0;

  // responses still owed by the block, oldest first
  list_response_t pending_responses [$];

  int fail_count = 0;
  int requests_sent = 0;
  int responses_checked = 0;
  int full_refusals = 0;
  int empty_takes = 0;
  int remove_misses = 0;
  int wrap_takes = 0;

  round_robin_ready_list #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .ID_WIDTH    (ID_W)
  ) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_req_type     (in_req_type),
    .in_item_id      (in_item_id),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_ok          (out_ok),
    .out_current_id  (out_current_id),
    .out_entry_count (out_entry_count)
  );

  always #5 clk = ~clk;

  // directed part: empty list, unknown kind, extremes, duplicates,
  // removal before and at the position, a miss, then filling to the brim
  directed_row_t directed_rows [26] = '{
    // take on an empty list: refused, position untouched
    '{rrl_pkg::REQ_TAKE,   16'h0000, 1'b1, '{1'b0, 16'h0000, 5'd0}},
    // unknown kind is ignored
    '{rrl_pkg::REQ_NONE,   16'hFFFF, 1'b1, '{1'b0, 16'h0000, 5'd0}},
    '{rrl_pkg::REQ_PUSH,   16'hFFFF, 1'b1, '{1'b1, 16'h0000, 5'd1}},
    '{rrl_pkg::REQ_PUSH,   16'h0000, 1'b1, '{1'b1, 16'h0000, 5'd2}},
    // a duplicate id at the tail
    '{rrl_pkg::REQ_PUSH,   16'hFFFF, 1'b1, '{1'b1, 16'h0000, 5'd3}},
    '{rrl_pkg::REQ_TAKE,   16'h0000, 1'b1, '{1'b1, 16'hFFFF, 5'd3}},
    // id is ignored on a take
    '{rrl_pkg::REQ_TAKE,   16'hFFFF, 1'b1, '{1'b1, 16'h0000, 5'd3}},
    // removal before the position pulls it down
    '{rrl_pkg::REQ_REMOVE, 16'h0000, 1'b0, '0},
    // last of two matches sits at the position, which then falls off the end
    '{rrl_pkg::REQ_REMOVE, 16'hFFFF, 1'b0, '0},
    // no match
    '{rrl_pkg::REQ_REMOVE, 16'h5A5A, 1'b1, '{1'b0, 16'h0000, 5'd1}},
    '{rrl_pkg::REQ_PUSH,   16'h0001, 1'b0, '0},
    '{rrl_pkg::REQ_PUSH,   16'h0002, 1'b0, '0},
    '{rrl_pkg::REQ_PUSH,   16'h0004, 1'b0, '0},
    '{rrl_pkg::REQ_PUSH,   16'h0008, 1'b0, '0},
    '{rrl_pkg::REQ_PUSH,   16'h0010, 1'b0, '0},
    '{rrl_pkg::REQ_PUSH,   16'h0020, 1'b0, '0},
    '{rrl_pkg::REQ_PUSH,   16'h0040, 1'b0, '0},
    '{rrl_pkg::REQ_PUSH,   16'h0080, 1'b0, '0},
    '{rrl_pkg::REQ_PUSH,   16'h0100, 1'b0, '0},
    '{rrl_pkg::REQ_PUSH,   16'h0200, 1'b0, '0},
    '{rrl_pkg::REQ_PUSH,   16'h0400, 1'b0, '0},
    '{rrl_pkg::REQ_PUSH,   16'h0800, 1'b0, '0},
    '{rrl_pkg::REQ_PUSH,   16'h1000, 1'b0, '0},
    '{rrl_pkg::REQ_PUSH,   16'h2000, 1'b0, '0},
    '{rrl_pkg::REQ_PUSH,   16'h4000, 1'b0, '0},
    // push on a full list is refused
    '{rrl_pkg::REQ_PUSH,   16'h8000, 1'b1, '{1'b0, 16'h0000, 5'd16}}
  };

  // advance the predicted list by one request and return the response it owes
  function automatic list_response_t apply_request(rrl_pkg::rrl_req_t kind,
                                                   logic [ID_W-1:0] id);
    list_response_t resp;
    int             hit;
    resp = '0;
    hit  = -1;
    case (kind)
      rrl_pkg::REQ_PUSH: begin
        if (list_len < MAX_ENTRIES) begin
          list_ids[list_len] = id;
          list_len++;
          resp.ok = 1'b1;
        end
      end
      rrl_pkg::REQ_TAKE: begin
        if (list_len != 0) begin
          if (rr_pos >= list_len) rr_pos = 0;
          resp.ok         = 1'b1;
          resp.current_id = list_ids[rr_pos];
          // wrap after the last entry
          rr_pos = (rr_pos >= list_len - 1) ? 0 : rr_pos + 1;
        end
      end
      rrl_pkg::REQ_REMOVE: begin
        // last matching entry wins
        for (int i = 0; i < list_len; i++)
          if (list_ids[i] == id) hit = i;
        if (hit >= 0) begin
          for (int i = hit; i + 1 < list_len; i++) list_ids[i] = list_ids[i + 1];
          list_len--;
          if (hit < rr_pos) rr_pos--;
          if (rr_pos >= list_len) rr_pos = 0;
          resp.ok = 1'b1;
        end
      end
      default: ;
    endcase
    resp.entry_count = CNT_W'(list_len);
    return resp;
  endfunction

  // mostly back-to-back or short gaps, now and then a long one
  function automatic int pick_gap(bit quiet);
    int roll;
    roll = $urandom_range(0, 99);
    if (quiet || roll < 50) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // small pool so that duplicates and hits are common, plus extremes and wide values
  function automatic logic [ID_W-1:0] pick_id();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return ID_W'($urandom_range(0, 7));
    if (roll < 70) return ($urandom_range(0, 1) != 0) ? {ID_W{1'b1}} : {ID_W{1'b0}};
    return ID_W'($urandom());
  endfunction

  // offer one request after an idle gap, wait for it to be taken, then log what it owes
  task automatic offer_request(input rrl_pkg::rrl_req_t kind, input logic [ID_W-1:0] id,
                               input int gap, input logic typed,
                               input list_response_t typed_answer);
    list_response_t predicted;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_req_type <= kind;
    in_item_id  <= id;
    do @(posedge clk); while (in_stall !== 1'b0);
    // accepted at this edge
    predicted = apply_request(kind, id);
    pending_responses.push_back(typed ? typed_answer : predicted);
    requests_sent++;
    if (kind == rrl_pkg::REQ_PUSH && !predicted.ok) full_refusals++;
    if (kind == rrl_pkg::REQ_TAKE && !predicted.ok) empty_takes++;
    if (kind == rrl_pkg::REQ_REMOVE && !predicted.ok) remove_misses++;
    if (kind == rrl_pkg::REQ_TAKE && predicted.ok && rr_pos == 0) wrap_takes++;
  endtask

  // sender: reset, directed table, then random traffic in fill, drain and mixed phases
  initial begin : sender
    directed_row_t     row;
    rrl_pkg::rrl_req_t kind;
    logic [ID_W-1:0]   id;
    int                phase;
    int                push_share;
    int                roll;
    bit                quiet;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[n]) begin
      row = directed_rows[n];
      offer_request(row.kind, row.id, pick_gap(1'b0), row.typed, row.answer);
    end

    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      phase = (n / 120) % 3;
      // a stretch with no gaps from the sender
      quiet = (n >= 800 && n < 1000);
      push_share = (phase == 0) ? 65 : (phase == 1) ? 15 : 35;
      roll = $urandom_range(0, 99);
      if (roll < 3) kind = rrl_pkg::REQ_NONE;
      else if (roll < 3 + push_share) kind = rrl_pkg::REQ_PUSH;
      else if (roll < 3 + push_share + (97 - push_share) / 2) kind = rrl_pkg::REQ_TAKE;
      else kind = rrl_pkg::REQ_REMOVE;
      // removals mostly aim at an id that is really on the list
      if (kind == rrl_pkg::REQ_REMOVE && list_len > 0 && $urandom_range(0, 3) != 0)
        id = list_ids[$urandom_range(0, list_len - 1)];
      else
        id = pick_id();
      offer_request(kind, id, pick_gap(quiet), 1'b0, '0);
    end
    in_valid <= 1'b0;

    // drain what is still owed, then leave room for any stray response
    while (pending_responses.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("covered %0d requests, %0d responses checked, %0d takes that wrapped",
             requests_sent, responses_checked, wrap_takes);
    $display("refusals seen: %0d pushes on a full list, %0d takes on an empty list, %0d %s",
             full_refusals, empty_takes, remove_misses, "missed removes");
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // receiver: random stalls, one long hold-off so the block backs up, and a stall-free stretch
  initial begin : receiver
    int rx_cycle;
    int roll;
    int len;
    bit held_off;
    rx_cycle = 0;
    held_off = 1'b0;
    @(posedge clk);
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (!held_off && rx_cycle >= 3000) begin
        // long hold-off while the sender keeps offering
        out_stall <= 1'b1;
        repeat (200) @(posedge clk);
        rx_cycle += 200;
        held_off = 1'b1;
      end else if (rx_cycle >= 15000 && rx_cycle < 20000) begin
        out_stall <= 1'b0;
        @(posedge clk);
        rx_cycle++;
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < 60) begin
          out_stall <= 1'b0;
          len = $urandom_range(1, 8);
        end else if (roll < 95) begin
          out_stall <= 1'b1;
          len = $urandom_range(1, 3);
        end else begin
          out_stall <= 1'b1;
          len = $urandom_range(20, 60);
        end
        repeat (len) @(posedge clk);
        rx_cycle += len;
      end
    end
  end

  // response checker: each taken response against the oldest one owed
  always @(posedge clk) begin : check_responses
    list_response_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pending_responses.size() == 0) begin
        $error("response with nothing owed: ok=%0b current_id=%h entry_count=%0d",
               out_ok, out_current_id, out_entry_count);
        fail_count++;
      end else begin
        want = pending_responses.pop_front();
        responses_checked++;
        if (out_ok !== want.ok) begin
          $error("ok: expected %0b, got %0b", want.ok, out_ok);
          fail_count++;
        end
        if (out_current_id !== want.current_id) begin
          $error("current_id: expected %h, got %h", want.current_id, out_current_id);
          fail_count++;
        end
        if (out_entry_count !== want.entry_count) begin
          $error("entry_count: expected %0d, got %0d", want.entry_count, out_entry_count);
          fail_count++;
        end
      end
    end
  end

  // watchdog well beyond the slowest correct run
  initial begin : watchdog
    #8_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
